// ===== hw/rtl/upi_pkg.sv =====
// Shared constants, codes and the CORDIC arctangent table for the pose integrator.
package upi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_IDX_W       = 5;

  // Channel and register field widths.
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int SPEED_W = 16;
  localparam int RATE_W  = 16;
  localparam int STEP_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Internal datapath widths.
  localparam int TRIG_W = 34;            // CORDIC x/y, Q1.30 with headroom
  localparam int ANG_W  = 28;            // CORDIC angle, radians * 2^24
  localparam int PROD_W = 2 * TRIG_W;    // shared multiplier result
  localparam int HSUM_W = 19;            // heading before wrap and clamp

  localparam logic signed [HSUM_W-1:0] PI_Q13      = 19'sd25736;
  localparam logic signed [HSUM_W-1:0] TWO_PI_Q13  = 19'sd51472;
  localparam logic signed [HSUM_W-1:0] HALF_PI_Q13 = 19'sd12868;
  localparam logic signed [TRIG_W-1:0] CORDIC_K_Q30 = 34'sd652032874;

  localparam logic [STEP_W-1:0] TIME_STEP_RST = 16'd655;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 2'd2;

  // atan(2^-i) in radians scaled by 2^24.
  function automatic logic [23:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [23:0] v;
    unique case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/upi_if.sv =====
// Valid/ready channel interfaces for command/tick words and pose result words.
interface upi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [upi_pkg::SPEED_W-1:0]  linear_speed;
  logic signed [upi_pkg::RATE_W-1:0]   turn_rate;

  modport source (output valid, output op, output linear_speed, output turn_rate,
                  input ready);
  modport sink   (input valid, input op, input linear_speed, input turn_rate,
                  output ready);
endinterface

interface upi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [upi_pkg::POS_W-1:0]    pos_x;
  logic signed [upi_pkg::POS_W-1:0]    pos_y;
  logic signed [upi_pkg::HEAD_W-1:0]   heading;
  logic signed [upi_pkg::SPEED_W-1:0]  speed_out;
  logic signed [upi_pkg::RATE_W-1:0]   rate_out;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output speed_out, output rate_out, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading,
                  input speed_out, input rate_out, output ready);
endinterface

// ===== hw/rtl/unicycle_pose_integrator_core.sv =====
// Unicycle dead-reckoning pose integrator with iterative CORDIC and one shared multiplier.
//
// in_chan carries words with op = 0 (velocity command: speed and turn rate are
// latched, no result) or op = 1 (tick: the pose advances one time step and one
// pose word goes out on out_chan). Ticks before the first command emit the pose
// unchanged. The cfg port writes the time step and loads the x or y position.
// A command leaves the sequencer idle. A tick with a command on hand runs the CORDIC
// iterations, then the steps around the shared multiplier (speed*dt, x and y
// products, turn*dt, heading wrap), then loads the output register, which raises
// out valid; the sequencer then returns to idle before the next word can be taken.
// A tick before any command goes straight from acceptance to the output register load.
// in_chan.ready is high only while the sequencer is idle, so one word is in
// work at a time; a finished result sits in the output register and the next
// word is accepted while it waits. A result that cannot enter the register
// because the receiver stalls holds the sequencer until the register frees.
// Reset (synchronous, active low) clears the pose, the stored command, the
// have-command flag and the output valid, and sets the time step to 655.
module unicycle_pose_integrator_core #(
  parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  upi_in_if.sink                             in_chan,
  upi_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [upi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [upi_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_STEPS - 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CORDIC = 8'b0000_0010,
    ST_MUL_VT = 8'b0000_0100,
    ST_MUL_C  = 8'b0000_1000,
    ST_MUL_S  = 8'b0001_0000,
    ST_MUL_W  = 8'b0010_0000,
    ST_HEAD   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [upi_pkg::STEP_W-1:0]          time_step_r;
  logic signed [upi_pkg::POS_W-1:0]    pose_x_r, pose_x_nxt;
  logic signed [upi_pkg::POS_W-1:0]    pose_y_r, pose_y_nxt;
  logic signed [upi_pkg::HEAD_W-1:0]   heading_r, heading_nxt;
  logic signed [upi_pkg::SPEED_W-1:0]  speed_r;
  logic signed [upi_pkg::RATE_W-1:0]   rate_r;
  logic                                have_cmd_r;

  logic signed [upi_pkg::TRIG_W-1:0]   cx_r, cy_r, vt_r;
  logic signed [upi_pkg::ANG_W-1:0]    cz_r;
  logic                                flip_r;
  logic [IterW-1:0]                    iter_r;
  logic signed [upi_pkg::PROD_W-1:0]   prod_r;

  logic                                out_valid_r;
  logic signed [upi_pkg::POS_W-1:0]    out_x_r, out_y_r;
  logic signed [upi_pkg::HEAD_W-1:0]   out_head_r;
  logic signed [upi_pkg::SPEED_W-1:0]  out_speed_r;
  logic signed [upi_pkg::RATE_W-1:0]   out_rate_r;

  logic in_acc, out_free, out_load;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign out_load      = (state_r == ST_DONE) && out_free;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pos_x     = out_x_r;
  assign out_chan.pos_y     = out_y_r;
  assign out_chan.heading   = out_head_r;
  assign out_chan.speed_out = out_speed_r;
  assign out_chan.rate_out  = out_rate_r;

  // Heading folded into [-pi/2, pi/2]; the CORDIC result is negated to match.
  logic signed [upi_pkg::HSUM_W-1:0] h_ext, h_fold;
  logic                              fold_flip;
  logic signed [upi_pkg::ANG_W-1:0]  z_init;

  always_comb begin
    h_ext     = upi_pkg::HSUM_W'(heading_r);
    h_fold    = h_ext;
    fold_flip = 1'b0;
    if (h_ext > upi_pkg::HALF_PI_Q13) begin
      h_fold    = h_ext - upi_pkg::PI_Q13;
      fold_flip = 1'b1;
    end else if (h_ext < -upi_pkg::HALF_PI_Q13) begin
      h_fold    = h_ext + upi_pkg::PI_Q13;
      fold_flip = 1'b1;
    end
    z_init = upi_pkg::ANG_W'(h_fold) <<< 11;
  end

  // One CORDIC micro-rotation per cycle.
  logic signed [upi_pkg::TRIG_W-1:0] xs, ys;
  logic signed [upi_pkg::ANG_W-1:0]  at;

  assign xs = cx_r >>> iter_r;
  assign ys = cy_r >>> iter_r;
  assign at = $signed({4'b0000, upi_pkg::atan_lut(upi_pkg::ATAN_IDX_W'(iter_r))});

  // Shared multiplier; its product is always registered.
  logic signed [upi_pkg::TRIG_W-1:0] mul_a, mul_b, ts_ext;
  logic signed [upi_pkg::PROD_W-1:0] mul_p;

  assign ts_ext = $signed({{(upi_pkg::TRIG_W - upi_pkg::STEP_W){1'b0}}, time_step_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_VT: begin
        mul_a = upi_pkg::TRIG_W'(speed_r);
        mul_b = ts_ext;
      end
      ST_MUL_C: begin
        mul_a = prod_r[upi_pkg::TRIG_W-1:0];
        mul_b = flip_r ? -cx_r : cx_r;
      end
      ST_MUL_S: begin
        mul_a = vt_r;
        mul_b = flip_r ? -cy_r : cy_r;
      end
      ST_MUL_W: begin
        mul_a = upi_pkg::TRIG_W'(rate_r);
        mul_b = ts_ext;
      end
      ST_IDLE, ST_CORDIC, ST_HEAD, ST_DONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Position step: round Q9.54 to Q16.16, keep the low 32 bits.
  logic signed [upi_pkg::PROD_W-1:0] pos_sum;
  logic signed [upi_pkg::POS_W-1:0]  pos_delta;

  assign pos_sum   = prod_r + (upi_pkg::PROD_W'(1) <<< 37);
  assign pos_delta = {{2{pos_sum[upi_pkg::PROD_W-1]}}, pos_sum[upi_pkg::PROD_W-1:38]};

  // Heading step: round Q4.28 to Q2.13, wrap once by 2*pi, then clamp.
  logic signed [upi_pkg::TRIG_W-1:0] hd_sum;
  logic signed [17:0]                hd_delta;
  logic signed [upi_pkg::HSUM_W-1:0] h_raw, h_wrap, h_sat;

  always_comb begin
    hd_sum   = prod_r[upi_pkg::TRIG_W-1:0] + upi_pkg::TRIG_W'(16384);
    hd_delta = hd_sum[32:15];
    h_raw    = upi_pkg::HSUM_W'(heading_r) + upi_pkg::HSUM_W'(hd_delta);
    h_wrap   = h_raw;
    if (h_raw > upi_pkg::PI_Q13) begin
      h_wrap = h_raw - upi_pkg::TWO_PI_Q13;
    end else if (h_raw < -upi_pkg::PI_Q13) begin
      h_wrap = h_raw + upi_pkg::TWO_PI_Q13;
    end
    h_sat = h_wrap;
    if (h_wrap > upi_pkg::PI_Q13) begin
      h_sat = upi_pkg::PI_Q13;
    end else if (h_wrap < -upi_pkg::PI_Q13) begin
      h_sat = -upi_pkg::PI_Q13;
    end
  end

  // Sequencer and pose next values.
  always_comb begin
    state_nxt   = state_r;
    pose_x_nxt  = pose_x_r;
    pose_y_nxt  = pose_y_r;
    heading_nxt = heading_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_chan.op == upi_pkg::OP_TICK)) begin
          state_nxt = have_cmd_r ? ST_CORDIC : ST_DONE;
        end
      end
      ST_CORDIC: begin
        if (iter_r == IterLast) begin
          state_nxt = ST_MUL_VT;
        end
      end
      ST_MUL_VT: state_nxt = ST_MUL_C;
      ST_MUL_C:  state_nxt = ST_MUL_S;
      ST_MUL_S: begin
        pose_x_nxt = pose_x_r + pos_delta;
        state_nxt  = ST_MUL_W;
      end
      ST_MUL_W: begin
        pose_y_nxt = pose_y_r + pos_delta;
        state_nxt  = ST_HEAD;
      end
      ST_HEAD: begin
        heading_nxt = h_sat[upi_pkg::HEAD_W-1:0];
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A start write loads the position at once.
    if (cfg_we && (cfg_index == upi_pkg::REG_START_X)) begin
      pose_x_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == upi_pkg::REG_START_Y)) begin
      pose_y_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_step_r <= upi_pkg::TIME_STEP_RST;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
      speed_r     <= '0;
      rate_r      <= '0;
      have_cmd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pose_x_r  <= pose_x_nxt;
      pose_y_r  <= pose_y_nxt;
      heading_r <= heading_nxt;
      if (cfg_we && (cfg_index == upi_pkg::REG_TIME_STEP)) begin
        time_step_r <= cfg_wdata[upi_pkg::STEP_W-1:0];
      end
      if (in_acc && (in_chan.op == upi_pkg::OP_CMD)) begin
        speed_r    <= in_chan.linear_speed;
        rate_r     <= in_chan.turn_rate;
        have_cmd_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (state_r == ST_MUL_C) begin
      vt_r <= prod_r[upi_pkg::TRIG_W-1:0];
    end
    if (state_r == ST_IDLE) begin
      cx_r   <= upi_pkg::CORDIC_K_Q30;
      cy_r   <= '0;
      cz_r   <= z_init;
      flip_r <= fold_flip;
      iter_r <= '0;
    end else if (state_r == ST_CORDIC) begin
      if (!cz_r[upi_pkg::ANG_W-1]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end
      iter_r <= iter_r + IterW'(1);
    end
    if (out_load) begin
      out_x_r     <= pose_x_r;
      out_y_r     <= pose_y_r;
      out_head_r  <= heading_r;
      out_speed_r <= speed_r;
      out_rate_r  <= rate_r;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the pose integrator core: directed table, then random phases.
module testbench;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 9;
  localparam int WORD_LATENCY = upi_pkg::CORDIC_STEPS_DEF + 7;
  localparam int RUN_LIMIT    = 4_000_000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 210;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;

  localparam logic [upi_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int     HDG_PI        = 25736;
  localparam int     HDG_TWO_PI    = 51472;
  localparam int     HDG_HALF_PI   = 12868;
  localparam longint CORDIC_GAIN   = 652032874;
  localparam int     ATAN_DEPTH    = 24;
  localparam int     STEP_AT_RESET = 655;

  typedef struct packed {
    logic                               op;
    logic signed [upi_pkg::SPEED_W-1:0] speed;
    logic signed [upi_pkg::RATE_W-1:0]  rate;
  } word_t;

  typedef struct packed {
    logic signed [upi_pkg::POS_W-1:0]   x;
    logic signed [upi_pkg::POS_W-1:0]   y;
    logic signed [upi_pkg::HEAD_W-1:0]  heading;
    logic signed [upi_pkg::SPEED_W-1:0] speed;
    logic signed [upi_pkg::RATE_W-1:0]  rate;
  } pose_t;

  typedef struct packed {
    bit                            is_reg;
    word_t                         wd;
    logic [upi_pkg::CFG_IDX_W-1:0] idx;
    logic [upi_pkg::CFG_W-1:0]     data;
    bit                            typed;
    pose_t                         want;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [upi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [upi_pkg::CFG_W-1:0]     cfg_wdata;

  upi_in_if  in_ch ();
  upi_out_if out_ch ();

  unicycle_pose_integrator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Expected state of the integrator, kept in step with every accepted word.
  logic [upi_pkg::POS_W-1:0]          est_x = '0;
  logic [upi_pkg::POS_W-1:0]          est_y = '0;
  int                                 est_heading = 0;
  logic signed [upi_pkg::SPEED_W-1:0] est_speed = '0;
  logic signed [upi_pkg::RATE_W-1:0]  est_rate = '0;
  bit                                 est_have_cmd = 1'b0;
  logic [upi_pkg::STEP_W-1:0]         est_step = upi_pkg::STEP_W'(STEP_AT_RESET);

  longint atan_rad24 [ATAN_DEPTH] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  pose_t expected_poses [$];
  row_t  dir_table [$];
  int    errors   = 0;
  bit    quiet    = 1'b0;
  bit    hold_req = 1'b0;

  // Rotation-mode CORDIC; headings beyond +-pi/2 are folded by pi and the result negated.
  function automatic void cordic_trig(input int hdg, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit     flip;
    int     a;
    x = CORDIC_GAIN;
    y = 0;
    a = hdg;
    flip = 1'b0;
    if (a > HDG_HALF_PI) begin
      a = a - HDG_PI;
      flip = 1'b1;
    end else if (a < -HDG_HALF_PI) begin
      a = a + HDG_PI;
      flip = 1'b1;
    end
    z = longint'(a) * 2048;
    for (int i = 0; i < upi_pkg::CORDIC_STEPS_DEF && i < ATAN_DEPTH; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_rad24[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_rad24[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Speed times trig times step is Q9.54; round to Q16.16.
  function automatic logic [upi_pkg::POS_W-1:0] pos_step(
      input logic signed [upi_pkg::SPEED_W-1:0] v, input longint trig);
    longint p;
    p = longint'(v) * trig * longint'(est_step);
    p = (p + (longint'(1) << 37)) >>> 38;
    return p[upi_pkg::POS_W-1:0];
  endfunction

  function automatic bit advance_pose(input word_t wd, output pose_t p);
    longint c, s, d;
    int     h;
    p = '0;
    if (wd.op == upi_pkg::OP_CMD) begin
      est_speed = wd.speed;
      est_rate = wd.rate;
      est_have_cmd = 1'b1;
      return 1'b0;
    end
    if (est_have_cmd) begin
      cordic_trig(est_heading, c, s);
      est_x = est_x + pos_step(est_speed, c);
      est_y = est_y + pos_step(est_speed, s);
      d = (longint'(est_rate) * longint'(est_step) + (longint'(1) << 14)) >>> 15;
      h = est_heading + int'(d);
      if (h > HDG_PI) h = h - HDG_TWO_PI;
      else if (h < -HDG_PI) h = h + HDG_TWO_PI;
      if (h > HDG_PI) h = HDG_PI;
      if (h < -HDG_PI) h = -HDG_PI;
      est_heading = h;
    end
    p.x = est_x;
    p.y = est_y;
    p.heading = est_heading[upi_pkg::HEAD_W-1:0];
    p.speed = est_speed;
    p.rate = est_rate;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic word_t rand_word(input logic op);
    word_t wd;
    wd.op = op;
    wd.speed = pick_value();
    wd.rate = pick_value();
    return wd;
  endfunction

  // A typed row expects the pose at rest: everything zero.
  function automatic row_t word_row(input logic op, input logic [15:0] v,
                                    input logic [15:0] w, input bit at_rest);
    row_t r;
    r = '0;
    r.wd.op = op;
    r.wd.speed = v;
    r.wd.rate = w;
    r.typed = at_rest;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [upi_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [upi_pkg::CFG_W-1:0] data);
    row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  task automatic send_word(input word_t wd, input bit typed, input pose_t want);
    pose_t p;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= wd.op;
    in_ch.linear_speed <= wd.speed;
    in_ch.turn_rate <= wd.rate;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (advance_pose(wd, p)) expected_poses.push_back(typed ? want : p);
  endtask

  // Registers change only with the block drained; a command leaves no word to wait for.
  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (2 * WORD_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [upi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [upi_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      upi_pkg::REG_TIME_STEP: est_step = data[upi_pkg::STEP_W-1:0];
      upi_pkg::REG_START_X:   est_x = data;
      upi_pkg::REG_START_Y:   est_y = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [upi_pkg::CFG_W-1:0] step_val, sx, sy;
    int                        sent, n;
    in_ch.valid <= 1'b0;
    in_ch.op <= upi_pkg::OP_TICK;
    in_ch.linear_speed <= '0;
    in_ch.turn_rate <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;

    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h0000, 16'h0000, 1'b0));
    // Tick fields are ignored, so extremes there must not disturb the pose.
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h7FFF, 16'h8000, 1'b1));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h7FFF, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h8000, 16'h8000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h0000, 16'h7FFF, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h0001, 16'hFFFF, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'hFFFF, 16'h0001, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    // Full-scale step and turn rate: wrap by 2*pi, then saturation from the second tick.
    dir_table.push_back(reg_row(upi_pkg::REG_TIME_STEP, 32'h0000_FFFF));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h7FFF, 16'h7FFF, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h8000, 16'h8000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(reg_row(upi_pkg::REG_START_X, 32'h7FFF_FFFF));
    dir_table.push_back(reg_row(upi_pkg::REG_START_Y, 32'h8000_0000));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(reg_row(upi_pkg::REG_TIME_STEP, 32'h0000_0000));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));
    dir_table.push_back(reg_row(upi_pkg::REG_TIME_STEP, 32'h0000_0001));
    dir_table.push_back(word_row(upi_pkg::OP_CMD,  16'h5555, 16'hAAAA, 1'b0));
    dir_table.push_back(word_row(upi_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_reg) begin
        go_idle();
        write_reg(dir_table[i].idx, dir_table[i].data);
      end else begin
        send_word(dir_table[i].wd, dir_table[i].typed, dir_table[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          step_val = 32'h0000_FFFF;
          sx = 32'h7FFF_FFFF;
          sy = 32'h8000_0000;
        end
        1: begin
          step_val = 32'h0000_0001;
          sx = 32'h8000_0000;
          sy = 32'h7FFF_FFFF;
        end
        2: begin
          step_val = 32'h0000_0000;
          sx = $urandom;
          sy = $urandom;
        end
        3: begin
          step_val = STEP_AT_RESET;
          sx = 32'h0000_0000;
          sy = 32'h0000_0000;
        end
        default: begin
          step_val = $urandom_range(1) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
          sx = $urandom;
          sy = $urandom;
        end
      endcase
      go_idle();
      write_reg(upi_pkg::REG_TIME_STEP, step_val);
      write_reg(upi_pkg::REG_START_X, sx);
      write_reg(upi_pkg::REG_START_Y, sy);
      if (ph % 2 == 1) write_reg(REG_SPARE, $urandom);
      quiet = (ph == 3);
      // The receiver backs off for a long while; the input fills up behind it.
      if (ph == 5) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(99) < 80) begin
          send_word(rand_word(upi_pkg::OP_CMD), 1'b0, '0);
          sent++;
          n = $urandom_range(1, 12);
          repeat (n) begin
            send_word(rand_word(upi_pkg::OP_TICK), 1'b0, '0);
            sent++;
          end
        end else begin
          send_word(rand_word($urandom_range(1) ? upi_pkg::OP_TICK : upi_pkg::OP_CMD),
                    1'b0, '0);
          sent++;
        end
      end
    end
    quiet = 1'b0;

    go_idle();
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : receiver
    int    hold_left;
    pose_t seen, want;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.x = out_ch.pos_x;
        seen.y = out_ch.pos_y;
        seen.heading = out_ch.heading;
        seen.speed = out_ch.speed_out;
        seen.rate = out_ch.rate_out;
        if (expected_poses.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("pose word with nothing expected: x=%0d y=%0d h=%0d v=%0d w=%0d",
                     seen.x, seen.y, seen.heading, seen.speed, seen.rate);
        end else begin
          want = expected_poses.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.heading !== want.heading ||
              seen.speed !== want.speed || seen.rate !== want.rate) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("pose mismatch: expected x=%0d y=%0d h=%0d v=%0d w=%0d",
                       want.x, want.y, want.heading, want.speed, want.rate);
              $display("               got      x=%0d y=%0d h=%0d v=%0d w=%0d",
                       seen.x, seen.y, seen.heading, seen.speed, seen.rate);
            end
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/upi_pkg.sv
hw/rtl/upi_if.sv
hw/rtl/unicycle_pose_integrator_core.sv
verif/testbench.sv
